// ----- rtl/core/twgd_pkg.sv -----
// ----------------------------------------------------------------------------
// twgd_pkg
// Types and constants shared by the touch wake gesture detector.
// ----------------------------------------------------------------------------
package twgd_pkg;

  localparam int COORD_W  = 12;
  localparam int TICK_W   = 32;
  localparam int GEST_W   = 2;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 12;
  localparam int IN_DW    = 64;
  localparam int OUT_DW   = 8;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_SWEEP_MODE    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_TAP_ENABLE    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SWAP_AXES     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_HEIGHT_LIMIT  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_POCKET_ENABLE = 3'd4;

  // gesture codes
  localparam logic [GEST_W-1:0] GEST_NONE  = 2'd0;
  localparam logic [GEST_W-1:0] GEST_WAKE  = 2'd1;
  localparam logic [GEST_W-1:0] GEST_SLEEP = 2'd2;
  localparam logic [GEST_W-1:0] GEST_DTAP  = 2'd3;

  // sweep position gates
  localparam logic [COORD_W-1:0] POS_100 = 12'd100;
  localparam logic [COORD_W-1:0] POS_200 = 12'd200;
  localparam logic [COORD_W-1:0] POS_300 = 12'd300;
  localparam logic [COORD_W-1:0] POS_400 = 12'd400;

  // sweep elapsed-tick gates
  localparam logic [TICK_W-1:0] DT_STAGE1 = 32'd25;
  localparam logic [TICK_W-1:0] DT_STAGE2 = 32'd50;
  localparam logic [TICK_W-1:0] DT_STAGE3 = 32'd75;

  // double tap gates
  localparam logic [TICK_W-1:0]  TAP_WINDOW   = 32'd800;
  localparam logic [TICK_W-1:0]  TAP_MIN_GAP  = 32'd10;
  localparam logic [TICK_W-1:0]  TAP_SPAN_MIN = 32'd12;
  localparam logic [TICK_W-1:0]  TAP_SPAN_MAX = 32'd120;
  localparam logic [COORD_W-1:0] TAP_Y_MIN    = 12'd50;
  localparam logic [COORD_W-1:0] TAP_Y_MAX    = 12'd1200;
  localparam logic [COORD_W-1:0] TAP_TOL      = 12'd75;

  localparam logic [CFG_DW-1:0] HEIGHT_LIMIT_RST = 12'd854;

  typedef struct packed {
    logic [1:0]         sweep_mode;
    logic               tap_enable;
    logic               swap_axes;
    logic [COORD_W-1:0] height_limit;
    logic               pocket_enable;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [TICK_W-1:0]  tick_time;
    logic               screen_off;
    logic               pocket_ok;
  } item_t;

  typedef struct packed {
    logic [1:0]         wake_stage;
    logic [1:0]         sleep_stage;
    logic [TICK_W-1:0]  sweep_start;
    logic [TICK_W-1:0]  tap_time0;
    logic [TICK_W-1:0]  tap_time1;
    logic [COORD_W-1:0] tap_x0;
    logic [COORD_W-1:0] tap_x1;
    logic [COORD_W-1:0] tap_y0;
    logic [COORD_W-1:0] tap_y1;
    logic [TICK_W-1:0]  tap_win;
  } gest_state_t;

endpackage

// ----- rtl/core/twgd_eval.sv -----
// ----------------------------------------------------------------------------
// twgd_eval
// Next-state and gesture decision for one touch item.
// ----------------------------------------------------------------------------
module twgd_eval (
  input  twgd_pkg::cfg_t             cfg,
  input  twgd_pkg::item_t            item,
  input  twgd_pkg::gest_state_t      st,
  output twgd_pkg::gest_state_t      st_nxt,
  output logic [twgd_pkg::GEST_W-1:0] gesture
);

  always_comb begin
    logic [twgd_pkg::COORD_W-1:0] pos;
    logic [twgd_pkg::COORD_W-1:0] hgt;
    logic [twgd_pkg::COORD_W-1:0] dx;
    logic [twgd_pkg::COORD_W-1:0] dy;
    logic [twgd_pkg::TICK_W-1:0]  dt;
    logic [twgd_pkg::TICK_W-1:0]  ws;
    logic [twgd_pkg::TICK_W-1:0]  since_win;
    logic [twgd_pkg::TICK_W-1:0]  since_tap;
    logic [twgd_pkg::GEST_W-1:0]  code;
    logic                         h_ok;

    st_nxt    = st;
    code      = twgd_pkg::GEST_NONE;
    pos       = cfg.swap_axes ? item.coord_y : item.coord_x;
    hgt       = cfg.swap_axes ? item.coord_x : item.coord_y;
    h_ok      = hgt > cfg.height_limit;
    dt        = item.tick_time - st.sweep_start;
    // a zero window start means no window open yet
    ws        = (st.tap_win == '0) ? item.tick_time : st.tap_win;
    since_win = item.tick_time - ws;
    since_tap = item.tick_time - st.tap_time0;
    dx        = (item.coord_x > st.tap_x0) ? item.coord_x - st.tap_x0
                                           : st.tap_x0 - item.coord_x;
    dy        = (item.coord_y > st.tap_y0) ? item.coord_y - st.tap_y0
                                           : st.tap_y0 - item.coord_y;

    if (!item.req_type) begin
      if (item.screen_off && cfg.sweep_mode != 2'd0 && h_ok) begin
        if (pos < twgd_pkg::POS_100) begin
          st_nxt.wake_stage  = 2'd1;
          st_nxt.sweep_start = item.tick_time;
        end else if (st.wake_stage == 2'd1 && pos > twgd_pkg::POS_100 &&
                     dt < twgd_pkg::DT_STAGE1) begin
          st_nxt.wake_stage = 2'd2;
        end else if (st.wake_stage == 2'd2 && pos > twgd_pkg::POS_200 &&
                     dt < twgd_pkg::DT_STAGE2) begin
          st_nxt.wake_stage = 2'd3;
        end else if (st.wake_stage == 2'd3 && pos > twgd_pkg::POS_300 &&
                     dt < twgd_pkg::DT_STAGE3) begin
          code = twgd_pkg::GEST_WAKE;
        end
      end else if (!item.screen_off && cfg.sweep_mode[1] && h_ok) begin
        if (pos > twgd_pkg::POS_400) begin
          st_nxt.sleep_stage = 2'd1;
          st_nxt.sweep_start = item.tick_time;
        end else if (st.sleep_stage == 2'd1 && pos < twgd_pkg::POS_400 &&
                     dt < twgd_pkg::DT_STAGE1) begin
          st_nxt.sleep_stage = 2'd2;
        end else if (st.sleep_stage == 2'd2 && pos < twgd_pkg::POS_300 &&
                     dt < twgd_pkg::DT_STAGE2) begin
          st_nxt.sleep_stage = 2'd3;
        end else if (st.sleep_stage == 2'd3 && pos < twgd_pkg::POS_200 &&
                     dt < twgd_pkg::DT_STAGE3) begin
          code = twgd_pkg::GEST_SLEEP;
        end
      end
    end else begin
      if (since_win > twgd_pkg::TAP_WINDOW) begin
        // window expired: everything cleared, tap dropped
        st_nxt = '0;
      end else begin
        st_nxt.tap_time1 = st.tap_time0;
        st_nxt.tap_time0 = item.tick_time;
        st_nxt.tap_win   = ws;
        // taps too close only move the time history
        if (since_tap >= twgd_pkg::TAP_MIN_GAP) begin
          st_nxt.tap_x1 = st.tap_x0;
          st_nxt.tap_x0 = item.coord_x;
          st_nxt.tap_y1 = st.tap_y0;
          st_nxt.tap_y0 = item.coord_y;
          if (item.screen_off && cfg.tap_enable &&
              item.coord_y > twgd_pkg::TAP_Y_MIN &&
              item.coord_y < twgd_pkg::TAP_Y_MAX &&
              since_win > twgd_pkg::TAP_SPAN_MIN &&
              since_win < twgd_pkg::TAP_SPAN_MAX &&
              dx < twgd_pkg::TAP_TOL && dy < twgd_pkg::TAP_TOL) begin
            code = twgd_pkg::GEST_DTAP;
          end
        end
      end
    end

    // pocket gate: a passed detection clears all gesture state, a blocked one reports nothing
    if (code != twgd_pkg::GEST_NONE) begin
      if (cfg.pocket_enable && item.pocket_ok) begin
        st_nxt = '0;
      end else begin
        code = twgd_pkg::GEST_NONE;
      end
    end

    gesture = code;
  end

endmodule

// ----- rtl/core/touch_wake_gesture_detector.sv -----
// ----------------------------------------------------------------------------
// touch_wake_gesture_detector
// Sweep-to-wake/sleep and double tap detection on a stream of touch items.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                               | tuser
//  in_     | in  | coord_x, coord_y, tick_time, screen_off, pocket_ok | req_type
//  out_    | out | wake_press                                        | gesture
//  cfg_    | in  | cfg_we, cfg_addr (register index), cfg_wdata      | -
//
//  One item per cycle sustained while results are taken; items pass the input
//  register, then the result register. The gesture state register feeds back
//  through one evaluation stage, which sets that rate. Synchronous active-low
//  reset clears valids and gesture state and loads the register defaults. A
//  stalled result holds the input register; new items are taken whenever the
//  stage ahead moves or the input register is empty.
// ----------------------------------------------------------------------------
module touch_wake_gesture_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // coord_x[11:0], coord_y[23:12], tick_time[55:24], screen_off[56],
  // pocket_ok[57], zero [63:58]
  input  logic [twgd_pkg::IN_DW-1:0]    in_tdata,
  // req_type[0]
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // wake_press[0], zero [7:1]
  output logic [twgd_pkg::OUT_DW-1:0]   out_tdata,
  // gesture[1:0]
  output logic [twgd_pkg::GEST_W-1:0]   out_tuser,
  input  logic                          cfg_we,
  input  logic [twgd_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [twgd_pkg::CFG_DW-1:0]   cfg_wdata
);

  twgd_pkg::cfg_t                cfg_r;
  twgd_pkg::item_t               item_r;
  twgd_pkg::gest_state_t         state_r;
  twgd_pkg::gest_state_t         state_nxt;
  logic                          s1_valid_r;
  logic                          out_valid_r;
  logic                          wake_r;
  logic [twgd_pkg::GEST_W-1:0]   gest_r;
  logic [twgd_pkg::GEST_W-1:0]   gest_nxt;
  logic                          s1_adv;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sweep_mode    <= 2'd0;
      cfg_r.tap_enable    <= 1'b0;
      cfg_r.swap_axes     <= 1'b0;
      cfg_r.height_limit  <= twgd_pkg::HEIGHT_LIMIT_RST;
      cfg_r.pocket_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        twgd_pkg::REG_SWEEP_MODE:    cfg_r.sweep_mode    <= cfg_wdata[1:0];
        twgd_pkg::REG_TAP_ENABLE:    cfg_r.tap_enable    <= cfg_wdata[0];
        twgd_pkg::REG_SWAP_AXES:     cfg_r.swap_axes     <= cfg_wdata[0];
        twgd_pkg::REG_HEIGHT_LIMIT:  cfg_r.height_limit  <= cfg_wdata;
        twgd_pkg::REG_POCKET_ENABLE: cfg_r.pocket_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.req_type   <= in_tuser;
      item_r.coord_x    <= in_tdata[11:0];
      item_r.coord_y    <= in_tdata[23:12];
      item_r.tick_time  <= in_tdata[55:24];
      item_r.screen_off <= in_tdata[56];
      item_r.pocket_ok  <= in_tdata[57];
    end
  end

  twgd_eval u_eval (
    .cfg     (cfg_r),
    .item    (item_r),
    .st      (state_r),
    .st_nxt  (state_nxt),
    .gesture (gest_nxt)
  );

  // gesture state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      gest_r <= gest_nxt;
      wake_r <= (gest_nxt != twgd_pkg::GEST_NONE);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(twgd_pkg::OUT_DW-1){1'b0}}, wake_r};
  assign out_tuser  = gest_r;

  // a press always carries a gesture code, and only then
  a_press_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (wake_r == (gest_r != twgd_pkg::GEST_NONE)))
    else $error("press flag and gesture code disagree");

  // a passed detection leaves no gesture state behind
  a_clear_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_valid_r && gest_nxt != twgd_pkg::GEST_NONE) |=> (state_r == '0))
    else $error("gesture state not cleared after press");

  // wake tracker moves up one stage at a time, or restarts/clears
  a_wake_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.wake_stage != $past(state_r.wake_stage)) |->
      (state_r.wake_stage == 2'd0 || state_r.wake_stage == 2'd1 ||
       state_r.wake_stage == $past(state_r.wake_stage) + 2'd1))
    else $error("wake tracker skipped a stage");

  // a press is only reported when the pocket gate is open
  a_pocket_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_valid_r && gest_nxt != twgd_pkg::GEST_NONE) |->
      (cfg_r.pocket_enable && item_r.pocket_ok))
    else $error("press reported with pocket gate closed");

endmodule

// ----- verif/touch_wake_gesture_detector_tb.sv -----
// ----------------------------------------------------------------------------
// touch_wake_gesture_detector_tb
// Streams touch items into the detector and checks each result against a
// cycle-free predictor of the sweep trackers and the double tap history.
// Directed items first, then random gesture attempts over several register
// settings, with idle and stall on both sides of the stream.
// ----------------------------------------------------------------------------
module touch_wake_gesture_detector_tb;
  import twgd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SEG_ITEMS    = 125;

  // --------------------------------------------------------------------------
  // expected results, with a private copy of registers and gesture state
  // --------------------------------------------------------------------------
  class gesture_scoreboard;
    typedef struct packed {
      logic       press;
      logic [1:0] gest;
    } result_t;

    logic [1:0]  sweep_mode;
    logic        tap_en;
    logic        swap;
    logic [11:0] height_lim;
    logic        pocket_en;

    logic [1:0]  wake_stg;
    logic [1:0]  sleep_stg;
    logic [31:0] sweep_t0;
    logic [31:0] tap_t[2];
    logic [11:0] tap_x[2];
    logic [11:0] tap_y[2];
    logic [31:0] win_t0;

    result_t     pending[$];
    int          errors;
    int          results;
    int          hits[4];

    function new();
      sweep_mode = 2'd0;
      tap_en     = 1'b0;
      swap       = 1'b0;
      height_lim = HEIGHT_LIMIT_RST;
      pocket_en  = 1'b1;
      errors     = 0;
      results    = 0;
      foreach (hits[i]) hits[i] = 0;
      clear_state();
    endfunction

    function void clear_state();
      wake_stg  = 2'd0;
      sleep_stg = 2'd0;
      sweep_t0  = '0;
      win_t0    = '0;
      for (int i = 0; i < 2; i++) begin
        tap_t[i] = '0;
        tap_x[i] = '0;
        tap_y[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_SWEEP_MODE:    sweep_mode = val[1:0];
        REG_TAP_ENABLE:    tap_en     = val[0];
        REG_SWAP_AXES:     swap       = val[0];
        REG_HEIGHT_LIMIT:  height_lim = val;
        REG_POCKET_ENABLE: pocket_en  = val[0];
        default: ;
      endcase
    endfunction

    // a detection only presses when the pocket gate passes; then all resets
    function logic [1:0] press_if_allowed(logic [1:0] code, logic pk);
      if (pocket_en && pk) begin
        clear_state();
        return code;
      end
      return GEST_NONE;
    endfunction

    function logic [1:0] sweep_step(item_t it);
      logic [11:0] pos;
      logic [11:0] h;
      logic [31:0] dt;
      pos = swap ? it.coord_y : it.coord_x;
      h   = swap ? it.coord_x : it.coord_y;
      dt  = it.tick_time - sweep_t0;
      if (it.screen_off && sweep_mode != 2'd0 && h > height_lim) begin
        if (pos < POS_100) begin
          wake_stg = 2'd1;
          sweep_t0 = it.tick_time;
        end else if (wake_stg == 2'd1 && pos > POS_100 && dt < DT_STAGE1) begin
          wake_stg = 2'd2;
        end else if (wake_stg == 2'd2 && pos > POS_200 && dt < DT_STAGE2) begin
          wake_stg = 2'd3;
        end else if (wake_stg == 2'd3 && pos > POS_300 && dt < DT_STAGE3) begin
          return press_if_allowed(GEST_WAKE, it.pocket_ok);
        end
      end else if (!it.screen_off && sweep_mode > 2'd1 && h > height_lim) begin
        if (pos > POS_400) begin
          sleep_stg = 2'd1;
          sweep_t0  = it.tick_time;
        end else if (sleep_stg == 2'd1 && pos < POS_400 && dt < DT_STAGE1) begin
          sleep_stg = 2'd2;
        end else if (sleep_stg == 2'd2 && pos < POS_300 && dt < DT_STAGE2) begin
          sleep_stg = 2'd3;
        end else if (sleep_stg == 2'd3 && pos < POS_200 && dt < DT_STAGE3) begin
          return press_if_allowed(GEST_SLEEP, it.pocket_ok);
        end
      end
      return GEST_NONE;
    endfunction

    function logic [1:0] tap_step(item_t it);
      logic [31:0] age;
      logic [31:0] gap;
      logic [31:0] span;
      logic [11:0] dx;
      logic [11:0] dy;
      tap_t[1] = tap_t[0];
      tap_t[0] = it.tick_time;
      if (win_t0 == '0) win_t0 = it.tick_time;
      age = it.tick_time - win_t0;
      // stale window: wipe everything, the tap itself is then dropped
      if (age > TAP_WINDOW) clear_state();
      gap = tap_t[0] - tap_t[1];
      if (gap < TAP_MIN_GAP) return GEST_NONE;
      tap_x[1] = tap_x[0];
      tap_x[0] = it.coord_x;
      tap_y[1] = tap_y[0];
      tap_y[0] = it.coord_y;
      dx   = (tap_x[0] > tap_x[1]) ? tap_x[0] - tap_x[1] : tap_x[1] - tap_x[0];
      dy   = (tap_y[0] > tap_y[1]) ? tap_y[0] - tap_y[1] : tap_y[1] - tap_y[0];
      span = tap_t[0] - win_t0;
      if (it.screen_off && tap_en && it.coord_y > TAP_Y_MIN && it.coord_y < TAP_Y_MAX &&
          span > TAP_SPAN_MIN && span < TAP_SPAN_MAX && dx < TAP_TOL && dy < TAP_TOL)
        return press_if_allowed(GEST_DTAP, it.pocket_ok);
      return GEST_NONE;
    endfunction

    function void note_item(item_t it);
      logic [1:0] code;
      result_t    r;
      code    = it.req_type ? tap_step(it) : sweep_step(it);
      r.press = (code != GEST_NONE);
      r.gest  = code;
      hits[code]++;
      pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic press, logic [1:0] gest);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: press=%0b gesture=%0d",
                                  press, gest));
        return;
      end
      want = pending.pop_front();
      results++;
      if (press !== want.press)
        report_mismatch($sformatf("result %0d wake_press=%0b, wanted %0b",
                                  results, press, want.press));
      if (gest !== want.gest)
        report_mismatch($sformatf("result %0d gesture=%0d, wanted %0d",
                                  results, gest, want.gest));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT
  // --------------------------------------------------------------------------
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic [GEST_W-1:0]   out_tuser;
  logic                cfg_we     = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr   = '0;
  logic [CFG_DW-1:0]   cfg_wdata  = '0;

  touch_wake_gesture_detector i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gesture_scoreboard sb;
  int          idle_in_pct  = 0;
  int          idle_out_pct = 0;
  int          n_items      = 0;
  int          cycles       = 0;
  logic [31:0] now          = 32'd1000;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check, then decide on stall for the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid === 1'b1 && out_tready)
        sb.check_result(out_tdata[0], out_tuser);
      out_tready <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic item_t mk(logic kind, logic [11:0] x, logic [11:0] y,
                               logic [31:0] t, logic off, logic pk);
    item_t it;
    it.req_type   = kind;
    it.coord_x    = x;
    it.coord_y    = y;
    it.tick_time  = t;
    it.screen_off = off;
    it.pocket_ok  = pk;
    return it;
  endfunction

  // sweep sample in tracker terms, placed on the axes the block expects, now and then on the swapped ones
  function automatic item_t sweep_at(logic [11:0] pos, logic [11:0] h, logic [31:0] t,
                                     logic off, logic pk);
    logic flip;
    flip = sb.swap;
    if ($urandom_range(99) < 8) flip = ~flip;
    return flip ? mk(1'b0, h, pos, t, off, pk) : mk(1'b0, pos, h, t, off, pk);
  endfunction

  function automatic logic pick_pk();
    return ($urandom_range(99) < 85);
  endfunction

  function automatic logic [11:0] pick_height();
    if (sb.height_lim == 12'hFFF || $urandom_range(99) < 10)
      return 12'($urandom_range(4095));
    return 12'($urandom_range(4095, int'(sb.height_lim) + 1));
  endfunction

  // gate value, sometimes exactly on the boundary so the stage does not advance
  function automatic logic [11:0] pick_pos(int lo, int hi, int edge_val);
    if ($urandom_range(99) < 12) return 12'(edge_val);
    return 12'($urandom_range(hi, lo));
  endfunction

  function automatic logic [11:0] near(logic [11:0] v);
    int d;
    int r;
    d = $urandom_range(90);
    r = $urandom_range(1) ? int'(v) + d : int'(v) - d;
    if (r < 0) r = 0;
    if (r > 4095) r = 4095;
    return 12'(r);
  endfunction

  task automatic send(item_t it);
    while ($urandom_range(99) < idle_in_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, it.pocket_ok, it.screen_off, it.tick_time, it.coord_y, it.coord_x};
    in_tuser  <= it.req_type;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_item(it);
    n_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic [1:0] mode, logic tap, logic swp,
                              logic [11:0] hlim, logic pen);
    logic [CFG_AW-1:0] idx[5];
    logic [CFG_DW-1:0] val[5];
    idx = '{REG_SWEEP_MODE, REG_TAP_ENABLE, REG_SWAP_AXES, REG_HEIGHT_LIMIT,
            REG_POCKET_ENABLE};
    val = '{12'(mode), 12'(tap), 12'(swp), hlim, 12'(pen)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wake_attempt();
    logic [31:0] t;
    logic        off;
    off = ($urandom_range(99) < 90);
    t   = now;
    send(sweep_at(12'($urandom_range(99)), pick_height(), t, off, pick_pk()));
    t += $urandom_range(27, 1);
    send(sweep_at(pick_pos(101, 250, 100), pick_height(), t, off, pick_pk()));
    t += $urandom_range(27, 1);
    send(sweep_at(pick_pos(201, 350, 200), pick_height(), t, off, pick_pk()));
    t += $urandom_range(27, 1);
    send(sweep_at(pick_pos(301, 4095, 300), pick_height(), t, off, pick_pk()));
    now = t;
  endtask

  task automatic sleep_attempt();
    logic [31:0] t;
    logic        off;
    off = ($urandom_range(99) < 10);
    t   = now;
    send(sweep_at(pick_pos(401, 4095, 400), pick_height(), t, off, pick_pk()));
    t += $urandom_range(27, 1);
    send(sweep_at(pick_pos(301, 399, 400), pick_height(), t, off, pick_pk()));
    t += $urandom_range(27, 1);
    send(sweep_at(pick_pos(201, 299, 300), pick_height(), t, off, pick_pk()));
    t += $urandom_range(27, 1);
    send(sweep_at(pick_pos(0, 199, 200), pick_height(), t, off, pick_pk()));
    now = t;
  endtask

  task automatic double_tap_attempt();
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] gap;
    logic        off;
    off = ($urandom_range(99) < 90);
    x   = 12'($urandom_range(4095));
    y   = ($urandom_range(99) < 10) ? 12'($urandom_range(4095))
                                    : 12'($urandom_range(1250, 30));
    send(mk(1'b1, x, y, now, off, pick_pk()));
    // a bounce inside the minimum gap now and then
    if ($urandom_range(99) < 20)
      send(mk(1'b1, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
              now + $urandom_range(9), off, pick_pk()));
    gap = $urandom_range(130, 5);
    send(mk(1'b1, near(x), near(y), now + gap, off, pick_pk()));
    now += gap;
  endtask

  task automatic noise();
    int n;
    n = $urandom_range(3, 1);
    repeat (n)
      send(mk(1'($urandom), 12'($urandom), 12'($urandom), $urandom, 1'($urandom),
              1'($urandom)));
  endtask

  task automatic random_segment(int target);
    int pick;
    while (n_items < target) begin
      pick = $urandom_range(99);
      if (pick < 30)      wake_attempt();
      else if (pick < 55) sleep_attempt();
      else if (pick < 85) double_tap_attempt();
      else                noise();
      pick = $urandom_range(99);
      if (pick < 5)       now = $urandom;
      else if (pick < 8)  now = 32'hFFFF_FFC0 + $urandom_range(60);
      else if (pick < 28) now += $urandom_range(3000, 801);
      else                now += $urandom_range(200, 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [1:0]  seg_mode[6];
    logic        seg_tap[6];
    logic        seg_swap[6];
    logic [11:0] seg_hlim[6];
    logic        seg_pen[6];
    int          target;

    sb = new();
    seg_mode = '{2'd2, 2'd1, 2'd3, 2'd2, 2'd0, 2'd2};
    seg_tap  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    seg_swap = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    seg_hlim = '{12'd854, 12'd0, 12'd500, 12'd4095, 12'd200, 12'd854};
    seg_pen  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: sweep and tap detection off, tap history must still move
    send(mk(1'b1, 12'd0, 12'd0, 32'd0, 1'b1, 1'b1));
    send(mk(1'b1, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send(mk(1'b0, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    drain();

    // mode three behaves as wake and sleep
    write_config(2'd3, 1'b1, 1'b0, 12'd854, 1'b1);
    send(mk(1'b0, 12'd50,  12'd900, 32'd1000, 1'b1, 1'b1));
    send(mk(1'b0, 12'd150, 12'd900, 32'd1010, 1'b1, 1'b1));
    send(mk(1'b0, 12'd250, 12'd900, 32'd1030, 1'b1, 1'b1));
    send(mk(1'b0, 12'd350, 12'd900, 32'd1060, 1'b1, 1'b1));
    // sleep sweep: first completion gated by pocket, retry passes
    send(mk(1'b0, 12'd500, 12'd900, 32'd2000, 1'b0, 1'b1));
    send(mk(1'b0, 12'd350, 12'd900, 32'd2010, 1'b0, 1'b1));
    send(mk(1'b0, 12'd250, 12'd900, 32'd2030, 1'b0, 1'b1));
    send(mk(1'b0, 12'd150, 12'd900, 32'd2060, 1'b0, 1'b0));
    send(mk(1'b0, 12'd100, 12'd900, 32'd2065, 1'b0, 1'b1));
    // double tap with a bounce too close to count as a position
    send(mk(1'b1, 12'd500, 12'd600, 32'd3000, 1'b1, 1'b1));
    send(mk(1'b1, 12'd505, 12'd603, 32'd3005, 1'b1, 1'b1));
    send(mk(1'b1, 12'd520, 12'd610, 32'd3050, 1'b1, 1'b1));
    // window runs out on the second tap
    send(mk(1'b1, 12'd500, 12'd600, 32'd4000, 1'b1, 1'b1));
    send(mk(1'b1, 12'd500, 12'd600, 32'd5000, 1'b1, 1'b1));
    // raw y at the upper tap bound
    send(mk(1'b1, 12'd100, 12'd1200, 32'd6000, 1'b1, 1'b1));
    send(mk(1'b1, 12'd100, 12'd1200, 32'd6050, 1'b1, 1'b1));
    drain();

    target = n_items;
    for (int s = 0; s < 6; s++) begin
      write_config(seg_mode[s], seg_tap[s], seg_swap[s], seg_hlim[s], seg_pen[s]);
      idle_in_pct  = (s < 2) ? 15 : (s < 4) ? 86 : 0;
      idle_out_pct = (s < 2) ? 86 : (s < 4) ? 15 : 0;
      target += SEG_ITEMS;
      random_segment(target);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d items over 8 register settings, %0d results checked",
             n_items, sb.results);
    $display("presses seen: wake %0d, sleep %0d, double tap %0d",
             sb.hits[GEST_WAKE], sb.hits[GEST_SLEEP], sb.hits[GEST_DTAP]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
